FILE: src/assert_macros.svh
// Assertion macros used by the checker of the divider.
// No dependencies; take in with an include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/idiv_pkg.sv
// Shared types, constants and helpers of the 64-bit integer divider.
// No dependencies; compile first.
`timescale 1ns / 1ps

package idiv_pkg;

    // Arithmetic width and the fixed width of the payload fields
    localparam int DATA_WIDTH = 64;
    localparam int FIELD_W    = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [CNT_W-1:0]      t_cnt;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIX
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic fix;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic zero;
    } t_sts;

    // Zero-extend an arithmetic word to field width
    function automatic t_field widen(t_word w);
        t_field f;
        f = '0;
        f[DATA_WIDTH-1:0] = w;
        return f;
    endfunction

endpackage

FILE: src/idiv_ifs.sv
// Valid/ready channel interfaces for the divider's request and response.
// Depends on idiv_pkg for the field widths.
`timescale 1ns / 1ps

interface idiv_req_if import idiv_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   op;
    t_field dividend;
    t_field divisor;

    modport source (output valid, op, dividend, divisor, input ready);
    modport sink   (input valid, op, dividend, divisor, output ready);
endinterface

interface idiv_rsp_if import idiv_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field quotient;
    t_field remainder;
    logic   div_by_zero;

    modport source (output valid, quotient, remainder, div_by_zero, input ready);
    modport sink   (input valid, quotient, remainder, div_by_zero, output ready);
endinterface

FILE: src/integer_divider_64.sv
// Radix-2 restoring divider, 64-bit, signed or unsigned, truncating toward
// zero. An item is accepted only while the divider is free; it then passes
// through a prep state that takes operand magnitudes, a loop of DATA_WIDTH
// (64) steps that settles one quotient bit per cycle through a single
// 65-bit trial subtractor, and a fix state that does the sign fix-up and
// loads the output register; a new item is taken once the controller is
// back in idle. A zero divisor skips the loop: prep goes straight to fix,
// and the result has div_by_zero set and zero quotient and remainder. The
// result sits in an output register, so a stalled consumer does not hold
// up the next division until a second result is ready. Depends on idiv_pkg,
// idiv_ifs, idiv_ctrl and idiv_dp.
`timescale 1ns / 1ps

module integer_divider_64 import idiv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    idiv_req_if.sink   i_req,
    idiv_rsp_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;

    // Sequencing
    idiv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Arithmetic
    idiv_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_req.op),
        .i_dividend    (i_req.dividend),
        .i_divisor     (i_req.divisor),
        .o_quotient    (o_rsp.quotient),
        .o_remainder   (o_rsp.remainder),
        .o_div_by_zero (o_rsp.div_by_zero)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule

FILE: src/idiv_ctrl.sv
// Controller of the divider: sequencing state machine, bit counter, result valid.
// Depends on idiv_pkg.
`timescale 1ns / 1ps

module idiv_ctrl import idiv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // Result register can take a new item when empty or being drained
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = i_sts.zero ? ST_FIX : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == '0) n_state = ST_FIX;
            end
            ST_FIX: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_FIX: begin
                o_cmd.fix = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Bit counter and result valid
    always_comb begin
        n_cnt = r_cnt;
        if (o_cmd.prep) begin
            n_cnt = t_cnt'(DATA_WIDTH - 1);
        end else if (o_cmd.step) begin
            n_cnt = r_cnt - 1'b1;
        end

        n_out_valid = r_out_valid;
        if (o_cmd.fix) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: src/idiv_dp.sv
// Datapath of the divider: operand capture, sign handling, restoring step
// and result register. Depends on idiv_pkg.
`timescale 1ns / 1ps

module idiv_dp import idiv_pkg::*; (
    input  logic   i_clk,
    input  t_cmd   i_cmd,
    output t_sts   o_sts,
    input  logic   i_op,
    input  t_field i_dividend,
    input  t_field i_divisor,
    output t_field o_quotient,
    output t_field o_remainder,
    output logic   o_div_by_zero
);

    logic  r_signed;
    t_word r_nq;        // dividend bits shifting out, quotient bits shifting in
    t_word r_d;
    t_word r_r;         // partial remainder
    logic  r_n_neg, r_d_neg;
    t_word r_quot, r_rem;
    logic  r_dbz;

    t_word               w_rs;
    logic [DATA_WIDTH:0] w_diff;
    logic                w_ge;
    logic                w_zero;
    t_word               w_q_fix, w_r_fix;

    assign w_zero     = (r_d == '0);
    assign o_sts.zero = w_zero;

    // Restoring step: shift in next dividend bit, trial subtract with carry bit
    assign w_rs   = {r_r[DATA_WIDTH-2:0], r_nq[DATA_WIDTH-1]};
    assign w_diff = {r_r[DATA_WIDTH-1], w_rs} - {1'b0, r_d};
    assign w_ge   = !w_diff[DATA_WIDTH];

    // Sign fix-up; divide by zero forces both results to zero
    always_comb begin
        w_q_fix = (r_n_neg != r_d_neg) ? (~r_nq + 1'b1) : r_nq;
        w_r_fix = r_n_neg ? (~r_r + 1'b1) : r_r;
        if (w_zero) begin
            w_q_fix = '0;
            w_r_fix = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        // Capture operands at acceptance
        if (i_cmd.load) begin
            r_signed <= i_op;
            r_nq     <= i_dividend[DATA_WIDTH-1:0];
            r_d      <= i_divisor[DATA_WIDTH-1:0];
        end
        // Take magnitudes in signed mode and clear the partial remainder
        if (i_cmd.prep) begin
            r_n_neg <= r_signed && r_nq[DATA_WIDTH-1];
            r_d_neg <= r_signed && r_d[DATA_WIDTH-1];
            if (r_signed && r_nq[DATA_WIDTH-1]) r_nq <= ~r_nq + 1'b1;
            if (r_signed && r_d[DATA_WIDTH-1])  r_d  <= ~r_d + 1'b1;
            r_r <= '0;
        end
        // Advance one quotient bit
        if (i_cmd.step) begin
            r_r  <= w_ge ? w_diff[DATA_WIDTH-1:0] : w_rs;
            r_nq <= {r_nq[DATA_WIDTH-2:0], w_ge};
        end
        // Load the result register
        if (i_cmd.fix) begin
            r_quot <= w_q_fix;
            r_rem  <= w_r_fix;
            r_dbz  <= w_zero;
        end
    end

    assign o_quotient    = widen(r_quot);
    assign o_remainder   = widen(r_rem);
    assign o_div_by_zero = r_dbz;

endmodule

FILE: src/idiv_chk.sv
// Port-level checker for the divider, bound to the top level.
// Depends on assert_macros.svh and idiv_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module idiv_chk import idiv_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_field i_quotient,
    input t_field i_remainder,
    input logic   i_div_by_zero
);

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_quotient) && $stable(i_remainder) && $stable(i_div_by_zero), "result payload changed while stalled")

    // Divide by zero gives zero quotient and remainder
    `ASSERT_SAME(a_dbz_zero, i_clk, i_rst_n, i_out_valid && i_div_by_zero, (i_quotient == '0) && (i_remainder == '0), "nonzero result on divide by zero")

    // One item at a time: an accepted item closes the input for the next cycle
    `ASSERT_NEXT(a_one_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input open right after acceptance")

endmodule

bind integer_divider_64 idiv_chk u_idiv_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_quotient    (o_rsp.quotient),
    .i_remainder   (o_rsp.remainder),
    .i_div_by_zero (o_rsp.div_by_zero)
);
